// ===== rtl/core/mbsa_pkg.sv =====
// mbsa_pkg: shared types, widths and codes for the max-pool backward scatter block
// no dependencies; imported by every module of the block
`default_nettype none

package mbsa_pkg;

  // store geometry
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);

  // field widths
  localparam int unsigned GRAD_W  = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned PLANE_W = 12;
  localparam int unsigned PSIZE_W = 13;
  localparam int unsigned PROD_W  = PLANE_W + PSIZE_W;
  localparam int unsigned SUM_W   = PROD_W + 1;

  localparam logic [PSIZE_W-1:0] PSIZE_RESET = PSIZE_W'(4096);

  // action codes, code 3 acts as read then clear
  typedef enum logic [1:0] {
    ACT_ACCUM      = 2'd0,
    ACT_READ       = 2'd1,
    ACT_READ_CLEAR = 2'd2
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_SAT   = 2'd2
  } status_e;

  // resolved store address from the address generator
  typedef struct packed {
    logic              in_range;
    logic [ADDR_W-1:0] addr;
  } addr_info_t;

endpackage

`default_nettype wire

// ===== rtl/core/maxpool_backward_scatter_accumulate.sv =====
// maxpool_backward_scatter_accumulate: top level, sequencer and read-modify-write
// depends on mbsa_pkg, mbsa_addr_gen and mbsa_store
//
// Scatter-accumulates Q4.12 gradients into a store of STORE_DEPTH Q20.12 entries at
// plane*plane_size+position, and serves read and read-then-clear transactions. A
// transaction is taken when start_i is high and busy_o low; its result appears on
// read_value_o/status_o for one cycle with done_o high, and the next transaction can
// be taken in that same cycle; a new transaction is not taken before the last one is
// done. The sequencer steps through S_MUL for the plane base multiply, S_ADDR for
// the address add and range check plus the store read, and S_RMW for the modify and
// write back into the store. The receiver cannot hold results off. After reset the
// block sweeps all STORE_DEPTH (4096) entries to zero, one entry per cycle, with
// busy_o high. The plane_size register is written whenever cfg_valid_i is high
// (cfg_ready_o is always high) and must only change while idle.
`default_nettype none

module maxpool_backward_scatter_accumulate
  import mbsa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         action_i,
  input  wire logic signed [GRAD_W-1:0] grad_value_i,
  input  wire logic [POS_W-1:0]   position_i,
  input  wire logic [PLANE_W-1:0] plane_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [PSIZE_W-1:0] cfg_plane_size_i,
  output logic                    done_o,
  output logic signed [VALUE_W-1:0] read_value_o,
  output logic [1:0]              status_o
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_ADDR,
    S_RMW
  } state_e;

  state_e              state_q;
  logic [ADDR_W-1:0]   clr_cnt_q;
  logic [PSIZE_W-1:0]  psize_q;
  action_e             action_q;
  logic [GRAD_W-1:0]   grad_q;
  addr_info_t          info;
  addr_info_t          info_q;
  logic                accept;
  logic                done_q;
  logic [VALUE_W-1:0]  read_value_q;
  status_e             status_q;

  logic                rd_en;
  logic [VALUE_W-1:0]  rd_data;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [VALUE_W-1:0]  wr_data;

  logic [VALUE_W:0]    sum_ext;
  logic                sum_ovf;
  logic [VALUE_W-1:0]  sum_sat;
  logic [VALUE_W-1:0]  res_value;
  status_e             res_status;
  logic                res_write;
  logic [VALUE_W-1:0]  res_wdata;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psize_q <= PSIZE_RESET;
    end else if (cfg_valid_i) begin
      psize_q <= cfg_plane_size_i;
    end
  end

  // transaction payload held for the whole sequence
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_e'(action_i);
      grad_q   <= grad_value_i;
    end
    if (state_q == S_ADDR) begin
      info_q <= info;
    end
  end

  mbsa_addr_gen u_addr_gen (
    .clk_i       (clk_i),
    .load_i      (accept),
    .position_i  (position_i),
    .plane_i     (plane_i),
    .plane_size_i(psize_q),
    .info_o      (info)
  );

  // store read issued with the resolved address
  assign rd_en = (state_q == S_ADDR) && info.in_range;

  // saturating accumulate, both operands share 12 fraction bits
  assign sum_ext = {rd_data[VALUE_W-1], rd_data}
                 + {{(VALUE_W+1-GRAD_W){grad_q[GRAD_W-1]}}, grad_q};
  assign sum_ovf = sum_ext[VALUE_W] != sum_ext[VALUE_W-1];
  assign sum_sat = sum_ext[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                    : {1'b0, {(VALUE_W-1){1'b1}}};

  // result and write-back decode
  always_comb begin
    res_value  = '0;
    res_status = STAT_OK;
    res_write  = 1'b0;
    res_wdata  = '0;
    if (!info_q.in_range) begin
      res_status = STAT_RANGE;
    end else begin
      unique case (action_q)
        ACT_ACCUM: begin
          res_write  = 1'b1;
          res_wdata  = sum_ovf ? sum_sat : sum_ext[VALUE_W-1:0];
          res_status = sum_ovf ? STAT_SAT : STAT_OK;
        end
        ACT_READ: begin
          res_value = rd_data;
        end
        default: begin
          res_value = rd_data;
          res_write = 1'b1;
        end
      endcase
    end
  end

  // write port shared by the clear sweep and the write back
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = info_q.addr;
    wr_data = res_wdata;
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else if (state_q == S_RMW) begin
      wr_en   = res_write;
    end
  end

  mbsa_store u_store (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(info.addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // sequencer and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      done_q       <= 1'b0;
      read_value_q <= '0;
      status_q     <= STAT_OK;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_ADDR;
        end
        S_ADDR: begin
          state_q <= S_RMW;
        end
        S_RMW: begin
          state_q      <= S_IDLE;
          done_q       <= 1'b1;
          read_value_q <= res_value;
          status_q     <= res_status;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o       = done_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

// ===== rtl/core/mbsa_store.sv =====
// mbsa_store: gradient store, one write port and one registered read port
// depends on mbsa_pkg for depth and entry width
`default_nettype none

module mbsa_store
  import mbsa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rd_en_i,
  input  wire logic [ADDR_W-1:0]  rd_addr_i,
  output logic      [VALUE_W-1:0] rd_data_o,
  input  wire logic               wr_en_i,
  input  wire logic [ADDR_W-1:0]  wr_addr_i,
  input  wire logic [VALUE_W-1:0] wr_data_i
);

  logic [VALUE_W-1:0] mem [STORE_DEPTH];
  logic [VALUE_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, read data registered on the read enable
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/mbsa_addr_gen.sv =====
// mbsa_addr_gen: plane base multiply and range check, two register stages
// depends on mbsa_pkg for widths and the addr_info_t struct
`default_nettype none

module mbsa_addr_gen
  import mbsa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               load_i,
  input  wire logic [POS_W-1:0]   position_i,
  input  wire logic [PLANE_W-1:0] plane_i,
  input  wire logic [PSIZE_W-1:0] plane_size_i,
  output addr_info_t              info_o
);

  logic [POS_W-1:0]   pos_a_q;
  logic [PLANE_W-1:0] plane_a_q;
  logic [PSIZE_W-1:0] psize_a_q;
  logic [PROD_W-1:0]  prod_b_q;
  logic [POS_W-1:0]   pos_b_q;
  logic               pos_ok_b_q;
  logic [SUM_W-1:0]   addr_sum;

  // capture the transaction fields and the plane size in use
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pos_a_q   <= position_i;
      plane_a_q <= plane_i;
      psize_a_q <= plane_size_i;
    end
  end

  // plane base multiply and in-plane check
  always_ff @(posedge clk_i) begin
    prod_b_q   <= PROD_W'(plane_a_q) * PROD_W'(psize_a_q);
    pos_b_q    <= pos_a_q;
    pos_ok_b_q <= PSIZE_W'(pos_a_q) < psize_a_q;
  end

  // final address and store bound check
  assign addr_sum         = SUM_W'(prod_b_q) + SUM_W'(pos_b_q);
  assign info_o.in_range  = pos_ok_b_q && (addr_sum < SUM_W'(STORE_DEPTH));
  assign info_o.addr      = addr_sum[ADDR_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/mbsa_checker.sv =====
// mbsa_checker: port-level assertions for the scatter-accumulate top level
// depends on mbsa_pkg for status codes; bound to the top level below
`default_nettype none

module mbsa_checker
  import mbsa_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic               done_o,
  input wire logic signed [VALUE_W-1:0] read_value_o,
  input wire logic [1:0]         status_o
);

  // each accepted transaction returns its result with done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("result missing four cycles after accept");

  // an accepted transaction occupies the block
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after accept");

  // the result cycle frees the block for the next transaction
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("busy high while a result is shown");

  // skipped transactions return zero
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == STAT_RANGE)) |-> (read_value_o == '0))
    else $error("nonzero value on out-of-range result");

  // only defined status codes are reported
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == STAT_OK) || (status_o == STAT_RANGE)
             || (status_o == STAT_SAT)))
    else $error("undefined status code");

endmodule

bind maxpool_backward_scatter_accumulate mbsa_checker u_mbsa_checker (.*);

`default_nettype wire
